// File: hdl/rtk_pkg.sv
// Package with the romaji table, the shared types and the lookup functions of the converter.
package rtk_pkg;

   localparam int PendingMax = 3;
   localparam int WordBytes  = PendingMax + 1;
   localparam int KanaRows   = 125;

   localparam logic [15:0] KanaSmallTsu = 16'h3063;
   localparam logic [15:0] KanaN        = 16'h3093;

   typedef enum logic {
      OP_KEY    = 1'b0,
      OP_DELETE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [31:0] sp;   // right-aligned spelling, zero bytes above it
      logic [15:0] k1;
      logic [15:0] k2;
   } kana_row_type;

   typedef struct packed {
      logic       lone_n;
      logic [1:0] count;
      logic [7:0] letter0;
      logic [7:0] letter1;
      logic [7:0] letter2;
   } state_type;

   typedef struct packed {
      logic        status_flag;
      logic [1:0]  char_count;
      logic [15:0] first_code;
      logic [15:0] second_code;
      logic [1:0]  pending_length;
   } result_type;

   localparam kana_row_type KanaTable [KanaRows] = '{
      '{"a",16'h3042,16'h0},'{"i",16'h3044,16'h0},'{"u",16'h3046,16'h0},
      '{"e",16'h3048,16'h0},'{"o",16'h304A,16'h0},
      '{"ka",16'h304B,16'h0},'{"ki",16'h304D,16'h0},'{"ku",16'h304F,16'h0},
      '{"ke",16'h3051,16'h0},'{"ko",16'h3053,16'h0},
      '{"sa",16'h3055,16'h0},'{"shi",16'h3057,16'h0},'{"si",16'h3057,16'h0},
      '{"su",16'h3059,16'h0},'{"se",16'h305B,16'h0},'{"so",16'h305D,16'h0},
      '{"ta",16'h305F,16'h0},'{"chi",16'h3061,16'h0},'{"ti",16'h3061,16'h0},
      '{"tsu",16'h3064,16'h0},'{"tu",16'h3064,16'h0},'{"te",16'h3066,16'h0},
      '{"to",16'h3068,16'h0},
      '{"na",16'h306A,16'h0},'{"ni",16'h306B,16'h0},'{"nu",16'h306C,16'h0},
      '{"ne",16'h306D,16'h0},'{"no",16'h306E,16'h0},
      '{"ha",16'h306F,16'h0},'{"hi",16'h3072,16'h0},'{"fu",16'h3075,16'h0},
      '{"hu",16'h3075,16'h0},'{"he",16'h3078,16'h0},'{"ho",16'h307B,16'h0},
      '{"ma",16'h307E,16'h0},'{"mi",16'h307F,16'h0},'{"mu",16'h3080,16'h0},
      '{"me",16'h3081,16'h0},'{"mo",16'h3082,16'h0},
      '{"ya",16'h3084,16'h0},'{"yu",16'h3086,16'h0},'{"yo",16'h3088,16'h0},
      '{"ra",16'h3089,16'h0},'{"ri",16'h308A,16'h0},'{"ru",16'h308B,16'h0},
      '{"re",16'h308C,16'h0},'{"ro",16'h308D,16'h0},
      '{"wa",16'h308F,16'h0},'{"wo",16'h3092,16'h0},'{"nn",16'h3093,16'h0},
      '{"ga",16'h304C,16'h0},'{"gi",16'h304E,16'h0},'{"gu",16'h3050,16'h0},
      '{"ge",16'h3052,16'h0},'{"go",16'h3054,16'h0},
      '{"za",16'h3056,16'h0},'{"ji",16'h3058,16'h0},'{"zi",16'h3058,16'h0},
      '{"zu",16'h305A,16'h0},'{"ze",16'h305C,16'h0},'{"zo",16'h305E,16'h0},
      '{"da",16'h3060,16'h0},'{"di",16'h3062,16'h0},'{"du",16'h3065,16'h0},
      '{"de",16'h3067,16'h0},'{"do",16'h3069,16'h0},
      '{"ba",16'h3070,16'h0},'{"bi",16'h3073,16'h0},'{"bu",16'h3076,16'h0},
      '{"be",16'h3079,16'h0},'{"bo",16'h307C,16'h0},
      '{"pa",16'h3071,16'h0},'{"pi",16'h3074,16'h0},'{"pu",16'h3077,16'h0},
      '{"pe",16'h307A,16'h0},'{"po",16'h307D,16'h0},
      '{"kya",16'h304D,16'h3083},'{"kyu",16'h304D,16'h3085},'{"kyo",16'h304D,16'h3087},
      '{"sha",16'h3057,16'h3083},'{"shu",16'h3057,16'h3085},'{"sho",16'h3057,16'h3087},
      '{"sya",16'h3057,16'h3083},'{"syu",16'h3057,16'h3085},'{"syo",16'h3057,16'h3087},
      '{"cha",16'h3061,16'h3083},'{"chu",16'h3061,16'h3085},'{"cho",16'h3061,16'h3087},
      '{"tya",16'h3061,16'h3083},'{"tyu",16'h3061,16'h3085},'{"tyo",16'h3061,16'h3087},
      '{"nya",16'h306B,16'h3083},'{"nyu",16'h306B,16'h3085},'{"nyo",16'h306B,16'h3087},
      '{"hya",16'h3072,16'h3083},'{"hyu",16'h3072,16'h3085},'{"hyo",16'h3072,16'h3087},
      '{"mya",16'h307F,16'h3083},'{"myu",16'h307F,16'h3085},'{"myo",16'h307F,16'h3087},
      '{"rya",16'h308A,16'h3083},'{"ryu",16'h308A,16'h3085},'{"ryo",16'h308A,16'h3087},
      '{"gya",16'h304E,16'h3083},'{"gyu",16'h304E,16'h3085},'{"gyo",16'h304E,16'h3087},
      '{"ja",16'h3058,16'h3083},'{"ju",16'h3058,16'h3085},'{"jo",16'h3058,16'h3087},
      '{"bya",16'h3073,16'h3083},'{"byu",16'h3073,16'h3085},'{"byo",16'h3073,16'h3087},
      '{"pya",16'h3074,16'h3083},'{"pyu",16'h3074,16'h3085},'{"pyo",16'h3074,16'h3087},
      '{"xtu",16'h3063,16'h0},'{"xtsu",16'h3063,16'h0},
      '{"xa",16'h3041,16'h0},'{"xi",16'h3043,16'h0},'{"xu",16'h3045,16'h0},
      '{"xe",16'h3047,16'h0},'{"xo",16'h3049,16'h0},
      '{"xya",16'h3083,16'h0},'{"xyu",16'h3085,16'h0},'{"xyo",16'h3087,16'h0}
   };

   // Number of letters in a right-aligned spelling.
   function automatic logic [2:0] spell_len(input logic [31:0] sp);
      logic [2:0] n;
      n = 3'd0;
      for (int b = 0; b < WordBytes; b++) begin
         if (sp[8*b +: 8] != 8'h00) begin
            n = 3'(b + 1);
         end
      end
      return n;
   endfunction

   function automatic logic is_vowel(input logic [7:0] c);
      return (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
   endfunction

   // Exact match of a right-aligned word; every row is compared in parallel.
   function automatic kana_row_type exact_lookup(input logic [31:0] word,
                                                 output logic hit);
      kana_row_type found;
      found = '0;
      hit   = 1'b0;
      for (int r = 0; r < KanaRows; r++) begin
         if (!hit && KanaTable[r].sp == word) begin
            hit   = 1'b1;
            found = KanaTable[r];
         end
      end
      return found;
   endfunction

   // True when some longer row starts with the word of length len.
   function automatic logic prefix_hit(input logic [31:0] word, input logic [2:0] len);
      logic       hit;
      logic [2:0] rlen;
      hit = 1'b0;
      for (int r = 0; r < KanaRows; r++) begin
         rlen = spell_len(KanaTable[r].sp);
         if (rlen > len && (KanaTable[r].sp >> (8 * (rlen - len))) == word) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// File: hdl/rtk_if.sv
// Valid/ready channel interfaces for keystroke items and result items.
interface rtk_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] key_byte;

   modport source (output valid, output opcode, output key_byte, input ready);
   modport sink   (input valid, input opcode, input key_byte, output ready);
endinterface

interface rtk_rsp_if;
   logic        valid;
   logic        ready;
   logic        status_flag;
   logic [1:0]  char_count;
   logic [15:0] first_code;
   logic [15:0] second_code;
   logic [1:0]  pending_length;

   modport source (output valid, output status_flag, output char_count, output first_code,
                   output second_code, output pending_length, input ready);
   modport sink   (input valid, input status_flag, input char_count, input first_code,
                   input second_code, input pending_length, output ready);
endinterface

// File: hdl/rtk_step.sv
// Next-state and result logic for one item against the current pending state.
module rtk_step (
   input  logic                 opcode,
   input  logic [7:0]           key_byte,
   input  rtk_pkg::state_type   cur,
   output rtk_pkg::state_type   nxt,
   output rtk_pkg::result_type  res
);

   logic [31:0]           word;
   logic [2:0]            word_len;
   logic                  exact;
   logic                  pre;
   rtk_pkg::kana_row_type row;
   logic [1:0]            dec_count;
   logic [7:0]            c;

   assign c        = key_byte;
   assign word     = ({cur.letter0, cur.letter1, cur.letter2, 8'h00}
                      >> (8 * (2'd3 - cur.count))) | {24'h0, c};
   assign word_len = {1'b0, cur.count} + 3'd1;
   assign pre      = rtk_pkg::prefix_hit(word, word_len);
   assign dec_count = cur.count - 2'd1;

   always_comb begin
      row = rtk_pkg::exact_lookup(word, exact);
   end

   always_comb begin
      nxt = cur;
      res = '0;
      if (rtk_pkg::opcode_type'(opcode) == rtk_pkg::OP_DELETE) begin
         if (cur.count != 2'd0) begin
            nxt.count = dec_count;
            case (dec_count)
               2'd0:    nxt.letter0 = 8'h00;
               2'd1:    nxt.letter1 = 8'h00;
               default: nxt.letter2 = 8'h00;
            endcase
            if (dec_count == 2'd0) begin
               nxt.lone_n = 1'b0;
            end
            res.status_flag = 1'b1;
         end
      end else if (c < "a" || c > "z") begin
         nxt = '0;
         res.status_flag = 1'b1;
         res.char_count  = 2'd1;
         case (c)
            "-":     res.first_code = 16'h30FC;
            ",":     res.first_code = 16'h3001;
            ".":     res.first_code = 16'h3002;
            "[":     res.first_code = 16'h300C;
            "]":     res.first_code = 16'h300D;
            default: res.first_code = {8'h00, c};
         endcase
      end else if (cur.lone_n && c == "n") begin
         nxt = '0;
         res.status_flag = 1'b1;
         res.char_count  = 2'd1;
         res.first_code  = rtk_pkg::KanaN;
      end else if (cur.lone_n && c != "y" && !rtk_pkg::is_vowel(c)) begin
         nxt = '0;
         nxt.letter0 = c;
         nxt.count   = 2'd1;
         res.status_flag = 1'b1;
         res.char_count  = 2'd1;
         res.first_code  = rtk_pkg::KanaN;
      end else begin
         // A vowel or y after a waiting n drops the flag and carries on matching.
         nxt.lone_n = 1'b0;
         if (cur.count == 2'd0 && c == "n") begin
            nxt.letter0 = c;
            nxt.count   = 2'd1;
            nxt.lone_n  = 1'b1;
         end else if (cur.count == 2'd1 && cur.letter0 == c && c != "n"
                      && !rtk_pkg::is_vowel(c)) begin
            res.status_flag = 1'b1;
            res.char_count  = 2'd1;
            res.first_code  = rtk_pkg::KanaSmallTsu;
         end else if (exact) begin
            nxt = '0;
            res.status_flag = 1'b1;
            res.char_count  = (row.k2 != 16'h0) ? 2'd2 : 2'd1;
            res.first_code  = row.k1;
            res.second_code = row.k2;
         end else if (cur.count != 2'd3 && pre) begin
            nxt.count   = word_len[1:0];
            nxt.letter0 = (cur.count == 2'd0) ? c : cur.letter0;
            nxt.letter1 = (cur.count == 2'd1) ? c : cur.letter1;
            nxt.letter2 = (cur.count == 2'd2) ? c : cur.letter2;
         end else begin
            nxt = '0;
            nxt.letter0 = c;
            nxt.count   = 2'd1;
         end
      end
      res.pending_length = nxt.count;
   end

endmodule

// File: hdl/romaji_to_kana_converter_top.sv
// Top level of the romaji to kana converter: state store, step logic and result register.
// A result item appears on the rsp channel in the cycle after its key item is accepted.
// One item per cycle unless rsp stalls, set by the store's single read-modify-write.
// The store is read every cycle; the entry written in the previous cycle is forwarded.
// Reset is synchronous and active high; it empties the result register and marks the
// state store as unwritten, so the first item sees an empty buffer with no pending n.
module romaji_to_kana_converter_top (
   input  logic clock,
   input  logic reset,
   rtk_req_if.sink   req_if,
   rtk_rsp_if.source rsp_if
);

   // The pending state lives in a one-entry synchronous store. Its read data is registered,
   // so the word written on the last accepted item is held in a forward register and
   // replaces the stale read when the two collide.
   rtk_pkg::state_type state_mem [1];
   rtk_pkg::state_type rd_data_ff;
   rtk_pkg::state_type fwd_ff;
   logic               fwd_valid_ff;
   logic               written_ff;
   logic               written_in;

   rtk_pkg::state_type cur_state;
   rtk_pkg::state_type nxt_state;
   rtk_pkg::result_type step_res;

   rtk_pkg::result_type rsp_ff;
   rtk_pkg::result_type rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   // A new item is taken whenever the result register is empty or draining this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // Until the first write the store holds nothing, which reads as the reset state.
   always_comb begin
      if (!written_ff) begin
         cur_state = '0;
      end else if (fwd_valid_ff) begin
         cur_state = fwd_ff;
      end else begin
         cur_state = rd_data_ff;
      end
   end

   rtk_step u_step (
      .opcode   (req_if.opcode),
      .key_byte (req_if.key_byte),
      .cur      (cur_state),
      .nxt      (nxt_state),
      .res      (step_res)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         state_mem[0] <= nxt_state;
      end
      rd_data_ff <= state_mem[0];
      fwd_ff     <= nxt_state;
   end

   assign written_in   = written_ff || accept;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_in       = accept ? step_res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         fwd_valid_ff <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register loads the step result on an accepted item and otherwise holds
   // its item, so a stalled result stays unchanged until it is taken.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status_flag    = rsp_ff.status_flag;
   assign rsp_if.char_count     = rsp_ff.char_count;
   assign rsp_if.first_code     = rsp_ff.first_code;
   assign rsp_if.second_code    = rsp_ff.second_code;
   assign rsp_if.pending_length = rsp_ff.pending_length;

endmodule

// File: hdl/rtk_checker.sv
// Port-level checker for the converter and the bind that attaches it.
module rtk_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        status_flag,
   input logic [1:0]  char_count,
   input logic [15:0] first_code,
   input logic [15:0] second_code
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_code) && $stable(char_count))
      else $error("stalled result item changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> char_count != 2'd3)
      else $error("more than two characters committed");

   a_empty_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && char_count == 2'd0 |-> first_code == 16'h0 && second_code == 16'h0)
      else $error("codes present without committed characters");

   a_commit_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && char_count != 2'd0 |-> status_flag)
      else $error("characters committed without status flag");

endmodule

bind romaji_to_kana_converter_top rtk_checker u_rtk_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .status_flag (rsp_if.status_flag),
   .char_count  (rsp_if.char_count),
   .first_code  (rsp_if.first_code),
   .second_code (rsp_if.second_code)
);
